[design/uev_pkg.sv]
// ----------------------------------------------------------------------------
// uev_pkg: URL endpoint validator package
// Shared constants, state types and character helpers.
// ----------------------------------------------------------------------------
package uev_pkg;

    localparam int unsigned DefMaxLength = 256;

    localparam logic [1:0] PH_SCHEME = 2'd0;
    localparam logic [1:0] PH_HOST   = 2'd1;
    localparam logic [1:0] PH_PORT   = 2'd2;
    localparam logic [1:0] PH_PATH   = 2'd3;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_LOW  = 2'd1;
    localparam logic [1:0] ESC_HIGH = 2'd2;

    typedef logic [7:0] t_byte;

    function automatic logic f_is_digit(input t_byte c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_letter(input t_byte c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    // hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] f_hex(input t_byte c);
        logic [4:0] v;
        v = 5'h10;
        if (f_is_digit(c)) v = {1'b0, c[3:0]};
        else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    function automatic t_byte f_lower(input t_byte c);
        return ((c >= 8'h41) && (c <= 8'h5a)) ? (c | 8'h20) : c;
    endfunction

    function automatic t_byte f_secure(input logic [2:0] i);
        t_byte r;
        case (i)
            3'd0: r = "h";
            3'd1: r = "t";
            3'd2: r = "t";
            3'd3: r = "p";
            3'd4: r = "s";
            3'd5: r = ":";
            default: r = "/";
        endcase
        return r;
    endfunction

    function automatic t_byte f_plain(input logic [2:0] i);
        t_byte r;
        case (i)
            3'd0: r = "h";
            3'd1: r = "t";
            3'd2: r = "t";
            3'd3: r = "p";
            3'd4: r = ":";
            default: r = "/";
        endcase
        return r;
    endfunction

    function automatic logic f_private(input t_byte a, input t_byte b);
        return (a == 8'd10) || ((a == 8'd172) && (b >= 8'd16) && (b <= 8'd31)) ||
               ((a == 8'd192) && (b == 8'd168));
    endfunction

    function automatic logic f_public(input t_byte a, input t_byte b, input t_byte c);
        logic bad;
        bad = f_private(a, b) || (a == 8'd0) || (a == 8'd127) || (a >= 8'd224) ||
              ((a == 8'd100) && (b >= 8'd64) && (b <= 8'd127)) ||
              ((a == 8'd169) && (b == 8'd254)) ||
              ((a == 8'd192) && (b == 8'd0) && ((c == 8'd0) || (c == 8'd2))) ||
              ((a == 8'd198) && ((b == 8'd18) || (b == 8'd19) ||
                                 ((b == 8'd51) && (c == 8'd100)))) ||
              ((a == 8'd203) && (b == 8'd0) && (c == 8'd113));
        return !bad;
    endfunction

endpackage

[design/uev_stream_if.sv]
// ----------------------------------------------------------------------------
// uev_stream_if: valid/ready channel
// Carries one beat of payload of type T.
// ----------------------------------------------------------------------------
interface uev_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/uev_host_check.sv]
// ----------------------------------------------------------------------------
// uev_host_check: host verdict
// Decides from the accumulated host state whether the host is acceptable.
// ----------------------------------------------------------------------------
module uev_host_check
    import uev_pkg::*;
(
    input  logic       i_secure,
    input  logic       i_ip_ok,
    input  t_byte      i_oct0,
    input  t_byte      i_oct1,
    input  t_byte      i_oct2,
    input  logic [7:0] i_host_len,
    input  logic       i_dns_ok,
    input  logic       i_seen_dot,
    input  t_byte      i_prev,
    input  t_byte      i_win [10],
    output logic       o_ok
);
    logic tail_bad;
    logic dns_ok;

    always_comb begin
        tail_bad = ({i_win[4], i_win[5], i_win[6], i_win[7], i_win[8], i_win[9]}
                        == ".local") ||
                   ({i_win[0], i_win[1], i_win[2], i_win[3], i_win[4], i_win[5],
                     i_win[6], i_win[7], i_win[8], i_win[9]} == ".localhost") ||
                   ({i_win[1], i_win[2], i_win[3], i_win[4], i_win[5], i_win[6],
                     i_win[7], i_win[8], i_win[9]} == ".internal") ||
                   ({i_win[2], i_win[3], i_win[4], i_win[5], i_win[6], i_win[7],
                     i_win[8], i_win[9]} == ".invalid");
        dns_ok = i_dns_ok && (i_host_len >= 8'd3) && (i_host_len <= 8'd253) &&
                 f_is_letter(i_prev) && i_seen_dot && !tail_bad;
        if (i_host_len == 8'd0) o_ok = 1'b0;
        else if (i_secure) o_ok = i_ip_ok ? f_public(i_oct0, i_oct1, i_oct2) : dns_ok;
        else o_ok = i_ip_ok && f_private(i_oct0, i_oct1);
    end
endmodule

[design/url_endpoint_validator.sv]
// ----------------------------------------------------------------------------
// url_endpoint_validator: streaming URL endpoint check
// Byte-serial parser of scheme, host, port and path with one verdict per URL.
// ----------------------------------------------------------------------------
// One URL byte is taken per beat, one beat per cycle. The beat that carries
// last=1 produces one result beat (valid_res) in the next cycle through a single
// output register; other beats produce nothing. Each byte updates only small
// counters and flags, so the parser keeps up with the input every cycle; the
// input stalls only while a finished result waits for the sink and a new
// last beat would need the output register. A URL of MAX_LENGTH or more bytes
// is invalid. State returns to the scheme phase after every last beat.
module url_endpoint_validator
    import uev_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = DefMaxLength
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    uev_stream_if.sink       i_in,
    uev_stream_if.source     o_out
);
    localparam int PW = $clog2(MAX_LENGTH + 1);

    // parser state
    logic [PW-1:0] r_pos, n_pos;
    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_scheme, n_scheme;  // bit0 https, bit1 http
    logic          r_rej, n_rej;
    logic [1:0]    r_esc, n_esc;
    logic [3:0]    r_hi, n_hi;
    logic [1:0]    r_oidx, n_oidx;
    logic [1:0]    r_odig, n_odig;
    logic [8:0]    r_oacc, n_oacc;
    logic          r_olz, n_olz;
    logic          r_ipok, n_ipok;
    t_byte         r_oct [3];
    t_byte         n_oct [3];
    logic [7:0]    r_hlen, n_hlen;
    logic [6:0]    r_llen, n_llen;
    t_byte         r_prev, n_prev;
    logic          r_dot, n_dot;
    logic          r_dnsok, n_dnsok;
    t_byte         r_win [10];
    t_byte         n_win [10];
    logic [2:0]    r_pdig, n_pdig;
    logic [16:0]   r_pacc, n_pacc;
    logic [1:0]    r_path, n_path;

    // result register
    logic r_ovalid;
    logic r_res, n_res;

    logic  accept;
    t_byte c;
    logic  host_ok;
    logic [4:0] hx;
    logic [7:0] dec;
    logic [3:0] dig;
    logic [12:0] oprod;
    logic [20:0] pprod;

    assign c = i_in.data.character;
    assign i_in.ready = !r_ovalid || o_out.ready || !i_in.data.last;
    assign accept = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data.valid_res = r_res;

    uev_host_check u_host (
        .i_secure   (r_scheme[0]),
        .i_ip_ok    (r_ipok && (r_oidx == 2'd3) && (r_odig != 2'd0)),
        .i_oct0     (r_oct[0]),
        .i_oct1     (r_oct[1]),
        .i_oct2     (r_oct[2]),
        .i_host_len (r_hlen),
        .i_dns_ok   (r_dnsok),
        .i_seen_dot (r_dot),
        .i_prev     (r_prev),
        .i_win      (r_win),
        .o_ok       (host_ok)
    );

    always_comb begin
        n_pos = r_pos; n_phase = r_phase; n_scheme = r_scheme; n_rej = r_rej;
        n_esc = r_esc; n_hi = r_hi; n_oidx = r_oidx; n_odig = r_odig;
        n_oacc = r_oacc; n_olz = r_olz; n_ipok = r_ipok; n_oct = r_oct;
        n_hlen = r_hlen; n_llen = r_llen; n_prev = r_prev; n_dot = r_dot;
        n_dnsok = r_dnsok; n_win = r_win; n_pdig = r_pdig; n_pacc = r_pacc;
        n_path = r_path;
        hx = f_hex(c);
        dec = {r_hi, hx[3:0]};
        dig = c[3:0];
        oprod = r_oacc * 4'd10 + {9'd0, dig};
        pprod = r_pacc * 4'd10 + {17'd0, dig};

        if (r_pos < PW'(MAX_LENGTH)) n_pos = r_pos + 1'b1;
        if (c == 8'h00) n_rej = 1'b1;

        if (r_phase == PH_SCHEME) begin
            if (r_pos >= PW'(8) || c != f_secure(r_pos[2:0])) n_scheme[0] = 1'b0;
            if (r_pos >= PW'(7) || c != f_plain(r_pos[2:0])) n_scheme[1] = 1'b0;
            if (n_scheme == 2'b00) n_rej = 1'b1;
            if (r_pos == PW'(6) && n_scheme[1]) n_phase = PH_HOST;
            if (r_pos == PW'(7) && n_scheme[0]) n_phase = PH_HOST;
        end else begin
            if (c <= 8'h20 || c >= 8'h7f || c == "@" || c == "#" || c == "?" ||
                c == 8'h5c) n_rej = 1'b1;
            case (r_esc)
                ESC_HIGH: begin
                    if (hx[4]) n_rej = 1'b1;
                    else n_hi = hx[3:0];
                    n_esc = ESC_LOW;
                end
                ESC_LOW: begin
                    if (hx[4]) n_rej = 1'b1;
                    else if (dec <= 8'h20 || dec == 8'h7f || dec == 8'h5c) n_rej = 1'b1;
                    n_esc = ESC_NONE;
                end
                default: begin
                    if (c == "%") n_esc = ESC_HIGH;
                end
            endcase

            case (r_phase)
                PH_HOST: begin
                    if (c == ":" || c == "/") begin
                        if (!host_ok) n_rej = 1'b1;
                        n_phase = (c == ":") ? PH_PORT : PH_PATH;
                    end else begin
                        if (r_hlen != 8'd255) n_hlen = r_hlen + 8'd1;
                        if (r_ipok) begin
                            if (f_is_digit(c)) begin
                                if (r_odig == 2'd3 || (r_odig != 2'd0 && r_olz)) begin
                                    n_ipok = 1'b0;
                                end else begin
                                    n_oacc = oprod[8:0];
                                    if (oprod > 13'd255) n_ipok = 1'b0;
                                    if (r_odig == 2'd0 && dig == 4'd0) n_olz = 1'b1;
                                    n_odig = r_odig + 2'd1;
                                end
                            end else if (c == ".") begin
                                if (r_odig == 2'd0 || r_oidx == 2'd3) begin
                                    n_ipok = 1'b0;
                                end else begin
                                    n_oct[r_oidx] = r_oacc[7:0];
                                    n_oidx = r_oidx + 2'd1;
                                    n_odig = 2'd0;
                                    n_oacc = 9'd0;
                                    n_olz = 1'b0;
                                end
                            end else begin
                                n_ipok = 1'b0;
                            end
                        end
                        if (c == ".") begin
                            if (r_llen == 7'd0 || r_prev == "-") n_dnsok = 1'b0;
                            n_dot = 1'b1;
                            n_llen = 7'd0;
                        end else begin
                            if (!f_is_letter(c) && !f_is_digit(c) && c != "-")
                                n_dnsok = 1'b0;
                            if (r_llen == 7'd0 && c == "-") n_dnsok = 1'b0;
                            if (r_llen < 7'd64) n_llen = r_llen + 7'd1;
                            if (r_llen >= 7'd63) n_dnsok = 1'b0;
                        end
                        for (int i = 0; i < 9; i++) n_win[i] = r_win[i+1];
                        n_win[9] = f_lower(c);
                        n_prev = c;
                    end
                end
                PH_PORT: begin
                    if (f_is_digit(c)) begin
                        if (r_pdig == 3'd5) begin
                            n_rej = 1'b1;
                        end else begin
                            n_pacc = pprod[16:0];
                            n_pdig = r_pdig + 3'd1;
                            if (pprod > 21'd65535) n_rej = 1'b1;
                        end
                    end else if (c == "/") begin
                        if (r_pdig == 3'd0 || r_pacc == 17'd0) n_rej = 1'b1;
                        n_phase = PH_PATH;
                    end else begin
                        n_rej = 1'b1;
                    end
                end
                default: begin
                    if (r_path != 2'd3) n_path = r_path + 2'd1;
                end
            endcase
        end

        n_res = !n_rej && (n_pos < PW'(MAX_LENGTH)) && (n_phase == PH_PATH) &&
                (n_path != 2'd0) && (n_esc == ESC_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.data.last)) begin
            r_pos <= '0; r_phase <= PH_SCHEME; r_scheme <= 2'b11; r_rej <= 1'b0;
            r_esc <= ESC_NONE; r_hi <= '0; r_oidx <= '0; r_odig <= '0;
            r_oacc <= '0; r_olz <= 1'b0; r_ipok <= 1'b1;
            r_oct <= '{default: '0};
            r_hlen <= '0; r_llen <= '0; r_prev <= '0; r_dot <= 1'b0;
            r_dnsok <= 1'b1; r_win <= '{default: '0};
            r_pdig <= '0; r_pacc <= '0; r_path <= '0;
        end else if (accept) begin
            r_pos <= n_pos; r_phase <= n_phase; r_scheme <= n_scheme; r_rej <= n_rej;
            r_esc <= n_esc; r_hi <= n_hi; r_oidx <= n_oidx; r_odig <= n_odig;
            r_oacc <= n_oacc; r_olz <= n_olz; r_ipok <= n_ipok; r_oct <= n_oct;
            r_hlen <= n_hlen; r_llen <= n_llen; r_prev <= n_prev; r_dot <= n_dot;
            r_dnsok <= n_dnsok; r_win <= n_win; r_pdig <= n_pdig; r_pacc <= n_pacc;
            r_path <= n_path;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept && i_in.data.last) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.data.last) r_res <= n_res;
    end
endmodule

[design/uev_checker.sv]
// ----------------------------------------------------------------------------
// uev_checker: port-level checks
// Watches the top level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module uev_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_in_zero,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_res
);
    // a result only follows a last beat or a held result
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result without last beat");
    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_res)))
        else $error("stalled result changed");
    // a URL whose last byte is zero is never valid
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last && i_in_zero) |=> !i_out_res)
        else $error("zero byte accepted");
    // non-last beats are never stalled
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_last |-> i_in_ready)
        else $error("body beat stalled");
endmodule

bind url_endpoint_validator uev_checker u_uev_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.data.last),
    .i_in_zero   (i_in.data.character == 8'h00),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_res   (o_out.data.valid_res)
);
